>>> design/sbpv_pkg.sv
// ----------------------------------------------------------------------------
// sbpv_pkg
// Shared constants, register indexes and types for the sieve bitmap to prime
// value extractor.
// ----------------------------------------------------------------------------
package sbpv_pkg;

  localparam int VALUE_W   = 64;
  localparam int HALF_W    = 32;
  localparam int FLAG_W    = 8;
  localparam int BIT_IDX_W = 3;
  localparam int COUNT_W   = 19;
  localparam int CFG_IDX_W = 3;

  localparam logic [COUNT_W-1:0]   COUNT_MAX = '1;
  localparam logic [BIT_IDX_W-1:0] LAST_BIT  = BIT_IDX_W'(FLAG_W - 1);

  localparam int LINE_BYTES_DEF  = 32768;
  localparam int QUEUE_DEPTH_DEF = 4;

  localparam logic [CFG_IDX_W-1:0] REG_WHEEL_PRODUCT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CLASS_OFFSET  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LOWER_BOUND   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_UPPER_BOUND   = 3'd3;

  typedef struct packed {
    logic [VALUE_W-1:0] wheel_product;
    logic [VALUE_W-1:0] class_offset;
    logic [VALUE_W-1:0] lower_bound;
    logic [VALUE_W-1:0] upper_bound;
  } cfg_t;

  typedef struct packed {
    logic [FLAG_W-1:0]  flags;
    logic               first;
    logic [VALUE_W-1:0] mult;
  } entry_t;

endpackage

>>> design/sieve_bitmap_to_prime_values.sv
// ----------------------------------------------------------------------------
// sieve_bitmap_to_prime_values
// Turns wheel-sieve line bitmap bytes into the in-bounds values they flag.
// Path: a byte passes the two front stages, the queue, the back part's bit
//   walk, its pending register and the output register.
// Rate: the bit walk in the back part steps the eight flags of a byte and
//   stalls while a found value waits on the output; values leave at up to
//   one per cycle, and the front takes bytes ahead into a 4-deep queue.
// Reset: synchronous; clears position, count, queue and valid state and
//   loads the register reset values.
// ----------------------------------------------------------------------------
module sieve_bitmap_to_prime_values #(
  parameter int LineBytes  = sbpv_pkg::LINE_BYTES_DEF,
  parameter int QueueDepth = sbpv_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_wr_en,
  input  logic [sbpv_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [sbpv_pkg::VALUE_W-1:0]       cfg_wdata,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [sbpv_pkg::FLAG_W-1:0]        in_flag_byte,
  input  logic                               in_first_byte,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [sbpv_pkg::VALUE_W-1:0]       out_prime_value,
  output logic                               out_last_of_byte,
  output logic [sbpv_pkg::COUNT_W-1:0]       out_found_count
);

  sbpv_pkg::cfg_t                     cfg_r;
  sbpv_pkg::entry_t                   push_entry, head;
  logic                               push, pop, q_valid;
  logic [$clog2(QueueDepth+1)-1:0]    q_count;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.wheel_product <= sbpv_pkg::VALUE_W'(1);
      cfg_r.class_offset  <= '0;
      cfg_r.lower_bound   <= '0;
      cfg_r.upper_bound   <= '1;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        sbpv_pkg::REG_WHEEL_PRODUCT: cfg_r.wheel_product <= cfg_wdata;
        sbpv_pkg::REG_CLASS_OFFSET:  cfg_r.class_offset  <= cfg_wdata;
        sbpv_pkg::REG_LOWER_BOUND:   cfg_r.lower_bound   <= cfg_wdata;
        sbpv_pkg::REG_UPPER_BOUND:   cfg_r.upper_bound   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  sbpv_front #(
    .LineBytes  (LineBytes),
    .QueueDepth (QueueDepth)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_flag_byte  (in_flag_byte),
    .in_first_byte (in_first_byte),
    .wheel_product (cfg_r.wheel_product),
    .q_count       (q_count),
    .push          (push),
    .push_entry    (push_entry)
  );

  sbpv_queue #(
    .QueueDepth (QueueDepth)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .q_valid    (q_valid),
    .head       (head),
    .q_count    (q_count)
  );

  sbpv_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg_r),
    .q_valid          (q_valid),
    .head             (head),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_prime_value  (out_prime_value),
    .out_last_of_byte (out_last_of_byte),
    .out_found_count  (out_found_count)
  );

endmodule

>>> design/sbpv_front.sv
// ----------------------------------------------------------------------------
// sbpv_front
// Accepts flag bytes, tracks the byte position and forms
// wheel_product * position in two stages before queuing the item.
// ----------------------------------------------------------------------------
module sbpv_front #(
  parameter int LineBytes  = sbpv_pkg::LINE_BYTES_DEF,
  parameter int QueueDepth = sbpv_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [sbpv_pkg::FLAG_W-1:0]           in_flag_byte,
  input  logic                                  in_first_byte,
  input  logic [sbpv_pkg::VALUE_W-1:0]          wheel_product,
  input  logic [$clog2(QueueDepth+1)-1:0]       q_count,
  output logic                                  push,
  output sbpv_pkg::entry_t                      push_entry
);

  localparam int PW   = (LineBytes > 1) ? $clog2(LineBytes) : 1;
  localparam int QC_W = $clog2(QueueDepth + 1);
  localparam int HW   = sbpv_pkg::HALF_W;
  localparam logic [PW-1:0] POS_MAX = PW'(LineBytes - 1);

  logic [PW-1:0]                 pos_r, pos_nxt, pos_use;
  logic                          s1_v_r, s2_v_r;
  logic [sbpv_pkg::FLAG_W-1:0]   s1_flags_r, s2_flags_r;
  logic                          s1_first_r, s2_first_r;
  logic [PW-1:0]                 s1_pos_r;
  logic [HW+PW-1:0]              s2_lo_r, s2_lo_nxt;
  logic [HW-1:0]                 s2_hi_r, s2_hi_nxt;
  logic [QC_W:0]                 used;
  logic                          in_acc;

  // credit count: queued items plus items in flight
  assign used     = (QC_W+1)'(q_count) + (QC_W+1)'(s1_v_r) + (QC_W+1)'(s2_v_r);
  assign in_stall = (used >= (QC_W+1)'(QueueDepth));
  assign in_acc   = in_valid && !in_stall;

  assign pos_use = in_first_byte ? '0 : pos_r;
  assign pos_nxt = (pos_use < POS_MAX) ? pos_use + PW'(1) : POS_MAX;

  assign s2_lo_nxt = (HW+PW)'(wheel_product[HW-1:0]) * (HW+PW)'(s1_pos_r);
  assign s2_hi_nxt = HW'(wheel_product[sbpv_pkg::VALUE_W-1:HW] * HW'(s1_pos_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      s1_v_r <= in_acc;
      s2_v_r <= s1_v_r;
      if (in_acc) begin
        pos_r <= pos_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_flags_r <= in_flag_byte;
      s1_first_r <= in_first_byte;
      s1_pos_r   <= pos_use;
    end
    s2_flags_r <= s1_flags_r;
    s2_first_r <= s1_first_r;
    s2_lo_r    <= s2_lo_nxt;
    s2_hi_r    <= s2_hi_nxt;
  end

  assign push             = s2_v_r;
  assign push_entry.flags = s2_flags_r;
  assign push_entry.first = s2_first_r;
  assign push_entry.mult  = {s2_hi_r + HW'(s2_lo_r[HW+PW-1:HW]), s2_lo_r[HW-1:0]};

endmodule

>>> design/sbpv_queue.sv
// ----------------------------------------------------------------------------
// sbpv_queue
// Short queue of classified items between the front and back parts.
// ----------------------------------------------------------------------------
module sbpv_queue #(
  parameter int QueueDepth = sbpv_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            push,
  input  sbpv_pkg::entry_t                push_entry,
  input  logic                            pop,
  output logic                            q_valid,
  output sbpv_pkg::entry_t                head,
  output logic [$clog2(QueueDepth+1)-1:0] q_count
);

  localparam int AW   = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int QC_W = $clog2(QueueDepth + 1);
  localparam logic [AW-1:0] LAST_SLOT = AW'(QueueDepth - 1);

  sbpv_pkg::entry_t    slots_r [QueueDepth];
  logic [AW-1:0]       wr_r, rd_r;
  logic [QC_W-1:0]     count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r    <= '0;
      rd_r    <= '0;
      count_r <= '0;
    end else begin
      if (push) begin
        wr_r <= (wr_r == LAST_SLOT) ? '0 : wr_r + AW'(1);
      end
      if (pop) begin
        rd_r <= (rd_r == LAST_SLOT) ? '0 : rd_r + AW'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + QC_W'(1);
      end else if (pop && !push) begin
        count_r <= count_r - QC_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_r] <= push_entry;
    end
  end

  assign q_valid = (count_r != '0);
  assign head    = slots_r[rd_r];
  assign q_count = count_r;

endmodule

>>> design/sbpv_back.sv
// ----------------------------------------------------------------------------
// sbpv_back
// Walks the eight flags of each queued item, steps the value by
// wheel_product, filters by bounds and delivers values with count and
// end-of-byte mark.
// ----------------------------------------------------------------------------
module sbpv_back (
  input  logic                             clk,
  input  logic                             rst_n,
  input  sbpv_pkg::cfg_t                   cfg,
  input  logic                             q_valid,
  input  sbpv_pkg::entry_t                 head,
  output logic                             pop,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [sbpv_pkg::VALUE_W-1:0]     out_prime_value,
  output logic                             out_last_of_byte,
  output logic [sbpv_pkg::COUNT_W-1:0]     out_found_count
);

  logic                              busy_r;
  logic [sbpv_pkg::VALUE_W-1:0]      acc_r;
  logic [sbpv_pkg::FLAG_W-1:0]       flags_r;
  logic [sbpv_pkg::BIT_IDX_W-1:0]    j_r;
  logic [sbpv_pkg::COUNT_W-1:0]      cnt_r, cnt_inc;
  logic                              pend_v_r, pend_last_r;
  logic [sbpv_pkg::VALUE_W-1:0]      pend_val_r;
  logic [sbpv_pkg::COUNT_W-1:0]      pend_cnt_r;
  logic                              out_v_r, out_last_r;
  logic [sbpv_pkg::VALUE_W-1:0]      out_val_r;
  logic [sbpv_pkg::COUNT_W-1:0]      out_cnt_r;
  logic [sbpv_pkg::VALUE_W-1:0]      load_acc;
  logic                              in_bnd, hit, out_free, step, byte_end, load, pend_move;

  assign in_bnd    = (acc_r >= cfg.lower_bound) && (acc_r <= cfg.upper_bound);
  assign hit       = busy_r && flags_r[j_r] && in_bnd;
  assign out_free  = !out_v_r || !out_stall;
  assign step      = busy_r && (!hit || !pend_v_r || out_free);
  assign byte_end  = step && (j_r == sbpv_pkg::LAST_BIT);
  assign load      = q_valid && (!busy_r || byte_end);
  assign pend_move = pend_v_r && out_free && (pend_last_r || (step && hit));
  assign cnt_inc   = (cnt_r == sbpv_pkg::COUNT_MAX) ? cnt_r : cnt_r + sbpv_pkg::COUNT_W'(1);
  assign load_acc  = {head.mult[sbpv_pkg::VALUE_W-4:0], 3'b000} + cfg.class_offset;
  assign pop       = load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b0;
      pend_v_r <= 1'b0;
      out_v_r  <= 1'b0;
      cnt_r    <= '0;
    end else begin
      if (load) begin
        busy_r <= 1'b1;
      end else if (byte_end) begin
        busy_r <= 1'b0;
      end

      if (load && head.first) begin
        cnt_r <= '0;
      end else if (step && hit) begin
        cnt_r <= cnt_inc;
      end

      if (step && hit) begin
        pend_v_r <= 1'b1;
      end else if (pend_move) begin
        pend_v_r <= 1'b0;
      end

      if (pend_move) begin
        out_v_r <= 1'b1;
      end else if (out_free) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      acc_r   <= load_acc;
      flags_r <= head.flags;
      j_r     <= '0;
    end else if (step) begin
      acc_r <= acc_r + cfg.wheel_product;
      j_r   <= j_r + sbpv_pkg::BIT_IDX_W'(1);
    end

    // hold a found value until the next one or the byte's end shows whether it was the last
    if (step && hit) begin
      pend_val_r  <= acc_r;
      pend_cnt_r  <= cnt_inc;
      pend_last_r <= (j_r == sbpv_pkg::LAST_BIT);
    end else if (byte_end) begin
      pend_last_r <= 1'b1;
    end

    if (pend_move) begin
      out_val_r  <= pend_val_r;
      out_cnt_r  <= pend_cnt_r;
      out_last_r <= pend_last_r;
    end
  end

  assign out_valid        = out_v_r;
  assign out_prime_value  = out_val_r;
  assign out_last_of_byte = out_last_r;
  assign out_found_count  = out_cnt_r;

endmodule

>>> design/sbpv_checker.sv
// ----------------------------------------------------------------------------
// sbpv_checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module sbpv_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           out_valid,
  input logic                           out_stall,
  input logic [sbpv_pkg::VALUE_W-1:0]   out_prime_value,
  input logic                           out_last_of_byte,
  input logic [sbpv_pkg::COUNT_W-1:0]   out_found_count
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_prime_value)
      && $stable(out_last_of_byte) && $stable(out_found_count))
    else $error("result item changed while stalled");

  a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_found_count != '0)
    else $error("result item carries a zero count");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_last_of_byte && out_found_count != sbpv_pkg::COUNT_MAX
      ##1 out_valid |-> out_found_count != $past(out_found_count))
    else $error("count did not advance within a byte");

endmodule

bind sieve_bitmap_to_prime_values sbpv_checker u_sbpv_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_prime_value  (out_prime_value),
  .out_last_of_byte (out_last_of_byte),
  .out_found_count  (out_found_count)
);
